// ----- rtl/lac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_pkg
// shared widths, special labels, access bits and decision codes for the
// label access check block
// ----------------------------------------------------------------------------
package lac_pkg;

  // defaults for the top level parameters
  localparam int RULE_ENTRIES_DEF = 64;
  localparam int LABEL_BITS_DEF   = 16;

  // fixed field widths
  localparam int IN_LABEL_W = 16;
  localparam int MASK_W     = 6;
  localparam int RULE_IDX_W = 6;
  localparam int CODE_W     = 4;
  localparam int CFG_IDX_W  = 1;

  // rule compare results are reduced in groups of this size
  localparam int GROUP_SIZE = 8;

  // special labels
  localparam int LBL_HAT   = 3;
  localparam int LBL_STAR  = 4;
  localparam int LBL_FLOOR = 5;
  localparam int LBL_WEB   = 7;

  // access bits
  localparam logic [MASK_W-1:0] ACC_READ    = 6'b000001;
  localparam logic [MASK_W-1:0] ACC_WRITE   = 6'b000010;
  localparam logic [MASK_W-1:0] ACC_EXEC    = 6'b000100;
  localparam logic [MASK_W-1:0] ACC_LOCK    = 6'b100000;
  localparam logic [MASK_W-1:0] ACC_ANYREAD = ACC_READ | ACC_EXEC;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_DENIED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_ACCEPT = 1'b1;

  // command codes
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // rule scopes
  localparam logic SCOPE_SUBJECT = 1'b0;
  localparam logic SCOPE_TASK    = 1'b1;

  // decision codes
  typedef enum logic [CODE_W-1:0] {
    DEC_WRITE_ACK   = 4'd0,
    DEC_STAR_SUBJ   = 4'd1,
    DEC_WEB         = 4'd2,
    DEC_STAR_OBJ    = 4'd3,
    DEC_SAME_LABEL  = 4'd4,
    DEC_FLOOR_HAT   = 4'd5,
    DEC_RULE_OK     = 4'd6,
    DEC_NO_RULE     = 4'd7,
    DEC_TASK_RESTR  = 4'd8,
    DEC_OVERRIDE    = 4'd9
  } lac_code_t;

  // rule write control from the input stage to the rule table
  typedef struct packed {
    logic                  we;
    logic [RULE_IDX_W-1:0] idx;
    logic                  scope;
    logic                  valid;
    logic [MASK_W-1:0]     acc;
  } lac_wr_t;

endpackage

// ----- rtl/lac_rule_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_rule_table
// rule storage with parallel subject/object compare, registered match and
// satisfy vectors, then a registered first-match reduction per group
// ----------------------------------------------------------------------------
module lac_rule_table
  import lac_pkg::*;
#(
  parameter int RULE_ENTRIES = RULE_ENTRIES_DEF,
  parameter int LABEL_BITS   = LABEL_BITS_DEF,
  parameter int NUM_GROUPS   = (RULE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ld1,
  input  logic                  ld2,
  input  lac_wr_t               wr,
  input  logic [LABEL_BITS-1:0] subj,
  input  logic [LABEL_BITS-1:0] obj,
  input  logic [MASK_W-1:0]     req,
  output logic [NUM_GROUPS-1:0] grp_found0,
  output logic [NUM_GROUPS-1:0] grp_sat0,
  output logic [NUM_GROUPS-1:0] grp_found1,
  output logic [NUM_GROUPS-1:0] grp_sat1
);

  localparam int PADDED = NUM_GROUPS * GROUP_SIZE;

  // table storage
  logic [RULE_ENTRIES-1:0] valid_r;
  logic                    scope_r [RULE_ENTRIES];
  logic [LABEL_BITS-1:0]   subj_r  [RULE_ENTRIES];
  logic [LABEL_BITS-1:0]   obj_r   [RULE_ENTRIES];
  logic [MASK_W-1:0]       acc_r   [RULE_ENTRIES];

  // stage 1 vectors
  logic [PADDED-1:0] m0_nxt, s0_nxt, m1_nxt, s1_nxt;
  logic [PADDED-1:0] m0_r, s0_r, m1_r, s1_r;

  // stage 2 group results
  logic [NUM_GROUPS-1:0] gf0_nxt, gs0_nxt, gf1_nxt, gf1s_nxt;
  logic [NUM_GROUPS-1:0] gf0_r, gs0_r, gf1_r, gs1_r;

  // write implies lock, folded in when the rule is stored
  logic [MASK_W-1:0] acc_w;
  assign acc_w = ((wr.acc & ACC_WRITE) != '0) ? (wr.acc | ACC_LOCK) : wr.acc;

  genvar e;
  generate
    for (e = 0; e < PADDED; e++) begin : g_ent
      if (e < RULE_ENTRIES) begin : g_real
        logic hit;
        logic key_eq;
        logic covers;

        assign hit = wr.we && (32'(wr.idx) == 32'(e));

        always_ff @(posedge clk) begin
          if (!rst_n) begin
            valid_r[e] <= 1'b0;
          end else if (hit) begin
            valid_r[e] <= wr.valid;
          end
        end

        always_ff @(posedge clk) begin
          if (hit) begin
            scope_r[e] <= wr.scope;
            subj_r[e]  <= subj;
            obj_r[e]   <= obj;
            acc_r[e]   <= acc_w;
          end
        end

        assign key_eq = valid_r[e] && (subj_r[e] == subj) && (obj_r[e] == obj);
        assign covers = ((req & acc_r[e]) == req);
        assign m0_nxt[e] = key_eq && (scope_r[e] == SCOPE_SUBJECT);
        assign m1_nxt[e] = key_eq && (scope_r[e] == SCOPE_TASK);
        assign s0_nxt[e] = covers && (acc_r[e] != '0);
        assign s1_nxt[e] = covers;
      end else begin : g_pad
        assign m0_nxt[e] = 1'b0;
        assign m1_nxt[e] = 1'b0;
        assign s0_nxt[e] = 1'b0;
        assign s1_nxt[e] = 1'b0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (ld1) begin
      m0_r <= m0_nxt;
      s0_r <= s0_nxt;
      m1_r <= m1_nxt;
      s1_r <= s1_nxt;
    end
  end

  // lowest index wins inside each group
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      gf0_nxt[g]  = |m0_r[g*GROUP_SIZE +: GROUP_SIZE];
      gf1_nxt[g]  = |m1_r[g*GROUP_SIZE +: GROUP_SIZE];
      gs0_nxt[g]  = 1'b0;
      gf1s_nxt[g] = 1'b0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
        if (m0_r[g*GROUP_SIZE + i]) begin
          gs0_nxt[g] = s0_r[g*GROUP_SIZE + i];
        end
        if (m1_r[g*GROUP_SIZE + i]) begin
          gf1s_nxt[g] = s1_r[g*GROUP_SIZE + i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      gf0_r <= gf0_nxt;
      gs0_r <= gs0_nxt;
      gf1_r <= gf1_nxt;
      gs1_r <= gf1s_nxt;
    end
  end

  assign grp_found0 = gf0_r;
  assign grp_sat0   = gs0_r;
  assign grp_found1 = gf1_r;
  assign grp_sat1   = gs1_r;

endmodule

// ----- rtl/label_access_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_access_check
// label based access decision with a rule table, task restrictions and
// audit marking
// ----------------------------------------------------------------------------
// One input word is either a rule write or an access check, and each gives
// exactly one result word. The block takes one word per cycle while the result
// side is not stalled, and returns results in order; a word's result goes from
// the input register through the table compare and the group reduction to the
// decision and the output register. The rate rests on the rule table compare:
// every entry is compared against the check's labels in parallel, and the first
// match is found over the following stage. A rule write updates the table
// as the write leaves the input register, so a check right behind it sees
// the new rule. The table comes out of reset with every slot empty; there is
// no clearing pass. Configuration (audit policy bits) is taken at any time
// and is applied to results at the output stage.
// ----------------------------------------------------------------------------
module label_access_check
  import lac_pkg::*;
#(
  parameter int RULE_ENTRIES = RULE_ENTRIES_DEF,
  parameter int LABEL_BITS   = LABEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input word
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [IN_LABEL_W-1:0] in_subject_label,
  input  logic [IN_LABEL_W-1:0] in_object_label,
  input  logic [MASK_W-1:0]     in_request_mask,
  input  logic                  in_task_check,
  input  logic                  in_privileged,
  input  logic                  in_audit_requested,
  input  logic [RULE_IDX_W-1:0] in_rule_index,
  input  logic                  in_rule_scope,
  input  logic [MASK_W-1:0]     in_rule_access,
  input  logic                  in_rule_valid,
  // result word
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_granted,
  output logic [CODE_W-1:0]     out_decided_by,
  output logic                  out_log_event,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic                  cfg_data
);

  localparam int NUM_GROUPS = (RULE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
  // bits of the label ports that take part in a compare
  localparam int CPY_W = (LABEL_BITS < IN_LABEL_W) ? LABEL_BITS : IN_LABEL_W;

  // --------------------------------------------------------------------------
  // audit policy registers
  // --------------------------------------------------------------------------
  logic log_denied_r, log_accept_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_denied_r <= 1'b1;
      log_accept_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOG_DENIED: log_denied_r <= cfg_data;
        CFG_LOG_ACCEPT: log_accept_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow: each stage loads when it is empty or the next one moves
  // --------------------------------------------------------------------------
  logic v0_r, v1_r, v2_r, v3_r;
  logic rdy0, rdy1, rdy2, rdy3;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: input register, labels cut or widened to LABEL_BITS
  // --------------------------------------------------------------------------
  logic [LABEL_BITS-1:0] subj_nxt, obj_nxt;

  always_comb begin
    subj_nxt = '0;
    obj_nxt  = '0;
    subj_nxt[CPY_W-1:0] = in_subject_label[CPY_W-1:0];
    obj_nxt[CPY_W-1:0]  = in_object_label[CPY_W-1:0];
  end

  logic                  cmd0_r, task0_r, priv0_r, audit0_r;
  logic [LABEL_BITS-1:0] subj0_r, obj0_r;
  logic [MASK_W-1:0]     req0_r, racc0_r;
  logic [RULE_IDX_W-1:0] ridx0_r;
  logic                  rscope0_r, rvalid0_r;

  always_ff @(posedge clk) begin
    if (rdy0) begin
      cmd0_r    <= in_command;
      subj0_r   <= subj_nxt;
      obj0_r    <= obj_nxt;
      req0_r    <= in_request_mask;
      task0_r   <= in_task_check;
      priv0_r   <= in_privileged;
      audit0_r  <= in_audit_requested;
      ridx0_r   <= in_rule_index;
      rscope0_r <= in_rule_scope;
      racc0_r   <= in_rule_access;
      rvalid0_r <= in_rule_valid;
    end
  end

  // --------------------------------------------------------------------------
  // stage 0 -> 1: fixed label checks, table write and table compare
  // --------------------------------------------------------------------------
  logic      star_s, star_o, web, same, read_like, floor_hat;
  logic      hw_hit_nxt, hw_ok_nxt;
  lac_code_t hw_code_nxt;

  assign star_s    = (subj0_r == LABEL_BITS'(LBL_STAR));
  assign star_o    = (obj0_r == LABEL_BITS'(LBL_STAR));
  assign web       = (obj0_r == LABEL_BITS'(LBL_WEB)) || (subj0_r == LABEL_BITS'(LBL_WEB));
  assign same      = (subj0_r == obj0_r);
  // only read/exec bits, or only the lock bit; an empty request counts
  assign read_like = ((req0_r & ACC_ANYREAD) == req0_r) || ((req0_r & ACC_LOCK) == req0_r);
  assign floor_hat = (obj0_r == LABEL_BITS'(LBL_FLOOR)) || (subj0_r == LABEL_BITS'(LBL_HAT));

  always_comb begin
    hw_hit_nxt  = 1'b1;
    hw_ok_nxt   = 1'b1;
    hw_code_nxt = DEC_NO_RULE;
    if (star_s) begin
      hw_ok_nxt   = 1'b0;
      hw_code_nxt = DEC_STAR_SUBJ;
    end else if (web) begin
      hw_code_nxt = DEC_WEB;
    end else if (star_o) begin
      hw_code_nxt = DEC_STAR_OBJ;
    end else if (same) begin
      hw_code_nxt = DEC_SAME_LABEL;
    end else if (read_like && floor_hat) begin
      hw_code_nxt = DEC_FLOOR_HAT;
    end else begin
      hw_hit_nxt = 1'b0;
      hw_ok_nxt  = 1'b0;
    end
  end

  // the write lands as the write word moves on, ahead of any later check
  lac_wr_t wr;
  assign wr.we    = v0_r && rdy1 && (cmd0_r == CMD_WRITE);
  assign wr.idx   = ridx0_r;
  assign wr.scope = rscope0_r;
  assign wr.valid = rvalid0_r;
  assign wr.acc   = racc0_r;

  logic [NUM_GROUPS-1:0] grp_found0, grp_sat0, grp_found1, grp_sat1;

  lac_rule_table #(
    .RULE_ENTRIES (RULE_ENTRIES),
    .LABEL_BITS   (LABEL_BITS),
    .NUM_GROUPS   (NUM_GROUPS)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld1        (rdy1),
    .ld2        (rdy2),
    .wr         (wr),
    .subj       (subj0_r),
    .obj        (obj0_r),
    .req        (req0_r),
    .grp_found0 (grp_found0),
    .grp_sat0   (grp_sat0),
    .grp_found1 (grp_found1),
    .grp_sat1   (grp_sat1)
  );

  // side data that travels with the compare results
  logic      cmd1_r, task1_r, priv1_r, audit1_r, hw_hit1_r, hw_ok1_r;
  lac_code_t hw_code1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cmd1_r     <= cmd0_r;
      task1_r    <= task0_r;
      priv1_r    <= priv0_r;
      audit1_r   <= audit0_r;
      hw_hit1_r  <= hw_hit_nxt;
      hw_ok1_r   <= hw_ok_nxt;
      hw_code1_r <= hw_code_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1 -> 2: group reduction runs inside the table, side data follows
  // --------------------------------------------------------------------------
  logic      cmd2_r, task2_r, priv2_r, audit2_r, hw_hit2_r, hw_ok2_r;
  lac_code_t hw_code2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      cmd2_r     <= cmd1_r;
      task2_r    <= task1_r;
      priv2_r    <= priv1_r;
      audit2_r   <= audit1_r;
      hw_hit2_r  <= hw_hit1_r;
      hw_ok2_r   <= hw_ok1_r;
      hw_code2_r <= hw_code1_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2 -> 3: first matching group, then the decision
  // --------------------------------------------------------------------------
  logic      found0, sat0, found1, sat1;
  logic      ok, log_nxt;
  lac_code_t code;

  always_comb begin
    found0 = |grp_found0;
    found1 = |grp_found1;
    sat0   = 1'b0;
    sat1   = 1'b0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_found0[g]) begin
        sat0 = grp_sat0[g];
      end
      if (grp_found1[g]) begin
        sat1 = grp_sat1[g];
      end
    end
  end

  always_comb begin
    ok   = 1'b0;
    code = DEC_NO_RULE;
    if (hw_hit2_r) begin
      ok   = hw_ok2_r;
      code = hw_code2_r;
    end else if (found0 && sat0) begin
      ok   = 1'b1;
      code = DEC_RULE_OK;
    end
    if (task2_r) begin
      // a task restriction that does not cover the request overrules a grant
      if (ok && found1 && !sat1) begin
        ok   = 1'b0;
        code = DEC_TASK_RESTR;
      end
      if (!ok && priv2_r) begin
        ok   = 1'b1;
        code = DEC_OVERRIDE;
      end
    end
    log_nxt = audit2_r && (ok ? log_accept_r : log_denied_r);
    if (cmd2_r == CMD_WRITE) begin
      ok      = 1'b0;
      code    = DEC_WRITE_ACK;
      log_nxt = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: output register
  // --------------------------------------------------------------------------
  logic              granted3_r, log3_r;
  logic [CODE_W-1:0] code3_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      granted3_r <= ok;
      code3_r    <= code;
      log3_r     <= log_nxt;
    end
  end

  assign out_valid      = v3_r;
  assign out_granted    = granted3_r;
  assign out_decided_by = code3_r;
  assign out_log_event  = log3_r;

endmodule

// ----- rtl/lac_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_checker
// port level checks on the result channel of label_access_check
// ----------------------------------------------------------------------------
module lac_checker
  import lac_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_granted,
  input logic [CODE_W-1:0] out_decided_by,
  input logic              out_log_event
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted) &&
      $stable(out_decided_by) && $stable(out_log_event))
    else $error("result word changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // write acks are never grants and never logged
  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_decided_by == DEC_WRITE_ACK) |-> !out_granted && !out_log_event)
    else $error("write ack marked as grant or log");

  // denial codes always come with a denial
  a_deny_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_decided_by == DEC_STAR_SUBJ || out_decided_by == DEC_NO_RULE ||
      out_decided_by == DEC_TASK_RESTR) |-> !out_granted)
    else $error("denial code with grant");

  // a grant always comes with a grant code, and no code beyond override
  a_grant_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |-> (out_decided_by == DEC_WEB ||
      out_decided_by == DEC_STAR_OBJ || out_decided_by == DEC_SAME_LABEL ||
      out_decided_by == DEC_FLOOR_HAT || out_decided_by == DEC_RULE_OK ||
      out_decided_by == DEC_OVERRIDE))
    else $error("grant with a non-grant code");

endmodule

bind label_access_check lac_checker u_lac_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_granted    (out_granted),
  .out_decided_by (out_decided_by),
  .out_log_event  (out_log_event)
);

// ----- tb/tb_label_access_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_label_access_check
// self-checking bench for the label access check block: a directed pass over
// every decision path, then randomized rule writes and access checks under
// all audit policy settings, each result word compared against a local model
// ----------------------------------------------------------------------------
module tb_label_access_check;
  import lac_pkg::*;

  localparam int N_RULES      = RULE_ENTRIES_DEF;
  localparam int MAX_WAIT     = 8;     // longest sender gap / receiver stall
  localparam int DRAIN_CYCLES = 8;     // settle time for the four stage pipe
  localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int CHUNK_WORDS  = 80;
  localparam int CHUNKS       = 4;

  // one input word, one field per port
  typedef struct packed {
    logic                  command;
    logic [IN_LABEL_W-1:0] subject;
    logic [IN_LABEL_W-1:0] object;
    logic [MASK_W-1:0]     request;
    logic                  task_check;
    logic                  privileged;
    logic                  audit;
    logic [RULE_IDX_W-1:0] rule_index;
    logic                  rule_scope;
    logic [MASK_W-1:0]     rule_access;
    logic                  rule_valid;
  } word_t;

  // one result word
  typedef struct packed {
    logic      granted;
    lac_code_t code;
    logic      log_event;
  } decision_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  word_t                 in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_granted;
  logic [CODE_W-1:0]     out_decided_by;
  logic                  out_log_event;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic                  cfg_data = 1'b0;

  label_access_check uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_word.command),
    .in_subject_label   (in_word.subject),
    .in_object_label    (in_word.object),
    .in_request_mask    (in_word.request),
    .in_task_check      (in_word.task_check),
    .in_privileged      (in_word.privileged),
    .in_audit_requested (in_word.audit),
    .in_rule_index      (in_word.rule_index),
    .in_rule_scope      (in_word.rule_scope),
    .in_rule_access     (in_word.rule_access),
    .in_rule_valid      (in_word.rule_valid),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_granted        (out_granted),
    .out_decided_by     (out_decided_by),
    .out_log_event      (out_log_event),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // --------------------------------------------------------------------------
  // local copy of the block state: rule table and audit policy bits
  // --------------------------------------------------------------------------
  logic                  rule_used   [N_RULES];
  logic                  rule_scope  [N_RULES];
  logic [IN_LABEL_W-1:0] rule_subj   [N_RULES];
  logic [IN_LABEL_W-1:0] rule_obj    [N_RULES];
  logic [MASK_W-1:0]     rule_acc    [N_RULES];
  logic                  pol_log_denied = 1'b1;
  logic                  pol_log_accept = 1'b0;

  word_t     pending_words[$];       // stimulus not yet offered
  decision_t expected_decisions[$];  // one per accepted word, oldest first

  // stimulus pools, filled at time zero
  logic [IN_LABEL_W-1:0] label_pool[6];
  logic [IN_LABEL_W-1:0] special_labels[4];
  logic [MASK_W-1:0]     read_like[5];

  int n_errors;
  int n_checks;
  int n_writes;
  int n_granted;
  int code_hits[16];
  int n_settings;

  // random idling state: gap and stall counters plus "no idle" stretches
  int   in_gap;
  int   out_stall;
  logic in_no_gap;
  logic out_no_stall;
  int   quiet;

  initial begin
    forever #5 clk = ~clk;
  end

  // first matching rule by lowest slot; a rule with write also grants lock
  function automatic logic find_rule(input logic sc, input logic [IN_LABEL_W-1:0] s,
                                     input logic [IN_LABEL_W-1:0] o,
                                     output logic [MASK_W-1:0] acc);
    acc = '0;
    for (int i = 0; i < N_RULES; i++) begin
      if (rule_used[i] && rule_scope[i] == sc && rule_subj[i] == s && rule_obj[i] == o) begin
        acc = rule_acc[i];
        if ((acc & ACC_WRITE) != '0) acc = acc | ACC_LOCK;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // expected result of one word; a rule write also updates the table copy
  function automatic decision_t decide_access(input word_t w);
    decision_t        d;
    logic             ok;
    logic             hit;
    logic [MASK_W-1:0] acc;
    logic             read_only;
    d = '{granted: 1'b0, code: DEC_WRITE_ACK, log_event: 1'b0};
    if (w.command == CMD_WRITE) begin
      if (int'(w.rule_index) < N_RULES) begin
        rule_used[w.rule_index]  = w.rule_valid;
        rule_scope[w.rule_index] = w.rule_scope;
        rule_subj[w.rule_index]  = w.subject;
        rule_obj[w.rule_index]   = w.object;
        rule_acc[w.rule_index]   = w.rule_access;
      end
      return d;
    end
    // empty request counts as read-like
    read_only = ((w.request & ACC_ANYREAD) == w.request) ||
                ((w.request & ACC_LOCK) == w.request);
    if (w.subject == LBL_STAR) begin
      ok = 1'b0; d.code = DEC_STAR_SUBJ;
    end else if (w.object == LBL_WEB || w.subject == LBL_WEB) begin
      ok = 1'b1; d.code = DEC_WEB;
    end else if (w.object == LBL_STAR) begin
      ok = 1'b1; d.code = DEC_STAR_OBJ;
    end else if (w.subject == w.object) begin
      ok = 1'b1; d.code = DEC_SAME_LABEL;
    end else if (read_only && (w.object == LBL_FLOOR || w.subject == LBL_HAT)) begin
      ok = 1'b1; d.code = DEC_FLOOR_HAT;
    end else begin
      hit = find_rule(SCOPE_SUBJECT, w.subject, w.object, acc);
      if (hit && acc != '0 && (w.request & acc) == w.request) begin
        ok = 1'b1; d.code = DEC_RULE_OK;
      end else begin
        ok = 1'b0; d.code = DEC_NO_RULE;
      end
    end
    if (w.task_check) begin
      // a task rule can only narrow a grant; no task rule leaves it alone
      if (ok) begin
        hit = find_rule(SCOPE_TASK, w.subject, w.object, acc);
        if (hit && (w.request & acc) != w.request) begin
          ok = 1'b0; d.code = DEC_TASK_RESTR;
        end
      end
      if (!ok && w.privileged) begin
        ok = 1'b1; d.code = DEC_OVERRIDE;
      end
    end
    d.granted   = ok;
    d.log_event = w.audit && (ok ? pol_log_accept : pol_log_denied);
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // word builders
  // --------------------------------------------------------------------------
  function automatic word_t check_word(input logic [IN_LABEL_W-1:0] s,
                                       input logic [IN_LABEL_W-1:0] o,
                                       input logic [MASK_W-1:0] req,
                                       input logic tc, input logic pv, input logic au);
    word_t w;
    w = '0;
    w.command = CMD_CHECK;
    w.subject = s; w.object = o; w.request = req;
    w.task_check = tc; w.privileged = pv; w.audit = au;
    return w;
  endfunction

  function automatic word_t rule_word(input logic [RULE_IDX_W-1:0] idx, input logic sc,
                                      input logic [IN_LABEL_W-1:0] s,
                                      input logic [IN_LABEL_W-1:0] o,
                                      input logic [MASK_W-1:0] acc, input logic vld);
    word_t w;
    w = '0;
    w.command = CMD_WRITE;
    w.subject = s; w.object = o;
    w.rule_index = idx; w.rule_scope = sc; w.rule_access = acc; w.rule_valid = vld;
    // audit and override on a write must not leak into the ack
    w.audit = 1'b1; w.privileged = 1'b1;
    return w;
  endfunction

  // mostly a small pool so rules and checks meet, sometimes any label
  function automatic logic [IN_LABEL_W-1:0] pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return special_labels[$urandom_range(0, 3)];
    if (r < 85) return label_pool[$urandom_range(0, 5)];
    return IN_LABEL_W'($urandom_range(0, 65535));
  endfunction

  // every field random; labels and command fixed by the caller
  function automatic word_t random_word(input logic cmd, input logic [IN_LABEL_W-1:0] s,
                                        input logic [IN_LABEL_W-1:0] o);
    word_t w;
    w.command     = cmd;
    w.subject     = s;
    w.object      = o;
    w.request     = ($urandom_range(0, 3) == 0) ? read_like[$urandom_range(0, 4)]
                                                : MASK_W'($urandom_range(0, 63));
    w.task_check  = 1'($urandom_range(0, 1));
    w.privileged  = ($urandom_range(0, 9) < 3);
    w.audit       = ($urandom_range(0, 9) < 7);
    w.rule_index  = RULE_IDX_W'($urandom_range(0, 63));
    w.rule_scope  = 1'($urandom_range(0, 1));
    w.rule_access = MASK_W'($urandom_range(0, 63));
    w.rule_valid  = ($urandom_range(0, 7) != 0);
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus sequences
  // --------------------------------------------------------------------------
  task automatic load_directed();
    // rule setup: shadowed subject rule, empty rule, task restriction, top slot
    pending_words.push_back(rule_word(0, SCOPE_SUBJECT, 100, 200, ACC_READ | ACC_WRITE, 1'b1));
    pending_words.push_back(rule_word(1, SCOPE_SUBJECT, 100, 200, 6'h3F, 1'b1));
    pending_words.push_back(rule_word(2, SCOPE_SUBJECT, 101, 200, 6'h00, 1'b1));
    pending_words.push_back(rule_word(3, SCOPE_TASK, 100, 200, ACC_READ, 1'b1));
    pending_words.push_back(rule_word(63, SCOPE_SUBJECT, 16'hFFFF, 0, 6'h3F, 1'b1));
    // hardwired label comparisons in priority order
    pending_words.push_back(check_word(LBL_STAR, 100, ACC_READ, 1'b0, 1'b0, 1'b1));
    pending_words.push_back(check_word(100, LBL_WEB, 6'h3F, 1'b0, 1'b0, 1'b1));
    pending_words.push_back(check_word(LBL_WEB, 100, 6'h3F, 1'b0, 1'b0, 1'b1));
    pending_words.push_back(check_word(100, LBL_STAR, 6'h3F, 1'b0, 1'b0, 1'b1));
    pending_words.push_back(check_word(16'hFFFF, 16'hFFFF, 6'h3F, 1'b0, 1'b0, 1'b1));
    pending_words.push_back(check_word(LBL_STAR, LBL_STAR, 6'h3F, 1'b0, 1'b0, 1'b0));
    // floor object / hat subject only for read-like or lock-only requests
    pending_words.push_back(check_word(100, LBL_FLOOR, ACC_ANYREAD, 1'b0, 1'b0, 1'b1));
    pending_words.push_back(check_word(LBL_HAT, 100, ACC_LOCK, 1'b0, 1'b0, 1'b1));
    pending_words.push_back(check_word(LBL_HAT, 100, 6'h00, 1'b0, 1'b0, 1'b1));
    pending_words.push_back(check_word(LBL_HAT, 100, ACC_WRITE, 1'b0, 1'b0, 1'b1));
    // subject rules: write implies lock, lowest slot wins, empty rule denies
    pending_words.push_back(check_word(100, 200, ACC_LOCK, 1'b0, 1'b0, 1'b1));
    pending_words.push_back(check_word(100, 200, ACC_READ | ACC_WRITE, 1'b0, 1'b0, 1'b1));
    pending_words.push_back(check_word(100, 200, ACC_EXEC, 1'b0, 1'b0, 1'b1));
    pending_words.push_back(check_word(101, 200, 6'h00, 1'b0, 1'b0, 1'b1));
    pending_words.push_back(check_word(16'hFFFF, 0, 6'h3F, 1'b0, 1'b0, 1'b1));
    // task restriction and privilege override
    pending_words.push_back(check_word(100, 200, ACC_READ | ACC_WRITE, 1'b1, 1'b0, 1'b1));
    pending_words.push_back(check_word(100, 200, ACC_READ | ACC_WRITE, 1'b1, 1'b1, 1'b1));
    pending_words.push_back(check_word(100, 200, ACC_READ, 1'b1, 1'b0, 1'b1));
    pending_words.push_back(check_word(102, 200, ACC_READ, 1'b1, 1'b1, 1'b1));
    pending_words.push_back(check_word(102, 200, ACC_READ, 1'b0, 1'b1, 1'b1));
    pending_words.push_back(check_word(102, 200, ACC_READ, 1'b1, 1'b0, 1'b0));
    // drop slot 0, the wide rule behind it takes over
    pending_words.push_back(rule_word(0, SCOPE_SUBJECT, 100, 200, 6'h00, 1'b0));
    pending_words.push_back(check_word(100, 200, ACC_EXEC, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic load_random(input int count);
    int n;
    int k;
    logic [IN_LABEL_W-1:0] s;
    logic [IN_LABEL_W-1:0] o;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 6) begin
        // rule writes for one pair, then probes of that pair
        s = pick_label();
        o = pick_label();
        k = $urandom_range(1, 2);
        repeat (k) pending_words.push_back(random_word(CMD_WRITE, s, o));
        n += k;
        k = $urandom_range(1, 3);
        repeat (k) pending_words.push_back(random_word(CMD_CHECK, s, o));
        n += k;
      end else begin
        pending_words.push_back(random_word(1'($urandom_range(0, 1)), pick_label(),
                                            pick_label()));
        n++;
      end
    end
  endtask

  // sender runs dry, every result comes back, then the pipe settles;
  // sampled between edges so the driver and monitor updates are settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_decisions.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_policy(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_LOG_DENIED) pol_log_denied = val;
    else pol_log_accept = val;
  endtask

  // --------------------------------------------------------------------------
  // input driver: pops pending words, random gap before each one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : word_driver
    decision_t d;
    int        gap;
    logic      holding;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      holding = in_valid;
      gap     = in_gap;
      if (in_valid && in_ready) begin
        d = decide_access(in_word);
        expected_decisions.push_back(d);
        if (in_word.command == CMD_WRITE) n_writes++;
        else n_checks++;
        if (in_word.command == CMD_CHECK && d.granted) n_granted++;
        code_hits[d.code]++;
        holding = 1'b0;
        gap = in_no_gap ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 31) == 0) in_no_gap = !in_no_gap;
      end
      // valid stays up untouched while a word waits for ready
      if (!holding) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_gap <= gap;
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: compares each word with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    decision_t want;
    int        stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      stall = out_stall;
      if (out_valid && out_ready) begin
        if (expected_decisions.size() == 0) begin
          n_errors++;
          $display("%0t: result word with nothing expected: expected none, got %0b/%0d/%0b",
                   $time, out_granted, out_decided_by, out_log_event);
        end else begin
          want = expected_decisions.pop_front();
          if (out_granted !== want.granted) begin
            n_errors++;
            $display("%0t: granted mismatch: expected %0b, got %0b",
                     $time, want.granted, out_granted);
          end
          if (out_decided_by !== want.code) begin
            n_errors++;
            $display("%0t: decided_by mismatch: expected %0d (%s), got %0d",
                     $time, want.code, want.code.name(), out_decided_by);
          end
          if (out_log_event !== want.log_event) begin
            n_errors++;
            $display("%0t: log_event mismatch: expected %0b, got %0b",
                     $time, want.log_event, out_log_event);
          end
        end
        stall = out_no_stall ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 31) == 0) out_no_stall = !out_no_stall;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= stall - 1;
      end else begin
        out_ready <= 1'b1;
        out_stall <= 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: any handshake counts as progress
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, expected_decisions.size());
        $display("tb_label_access_check: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence: reset, directed words, then random phases per policy setting
  // --------------------------------------------------------------------------
  initial begin
    logic pol_denied[4];
    logic pol_accept[4];
    int   codes_seen;
    pol_denied = '{1'b0, 1'b1, 1'b0, 1'b1};
    pol_accept = '{1'b0, 1'b1, 1'b1, 1'b0};
    n_errors = 0; n_checks = 0; n_writes = 0; n_granted = 0;
    n_settings = 1;
    in_gap = 0; out_stall = 0; in_no_gap = 1'b0; out_no_stall = 1'b0;
    for (int i = 0; i < 16; i++) code_hits[i] = 0;
    for (int i = 0; i < N_RULES; i++) begin
      rule_used[i] = 1'b0; rule_scope[i] = 1'b0;
      rule_subj[i] = '0; rule_obj[i] = '0; rule_acc[i] = '0;
    end
    special_labels = '{IN_LABEL_W'(LBL_HAT), IN_LABEL_W'(LBL_STAR),
                       IN_LABEL_W'(LBL_FLOOR), IN_LABEL_W'(LBL_WEB)};
    read_like      = '{6'h00, ACC_READ, ACC_EXEC, ACC_ANYREAD, ACC_LOCK};
    label_pool[0]  = '0;
    label_pool[1]  = '1;
    for (int i = 2; i < 6; i++) label_pool[i] = IN_LABEL_W'($urandom_range(8, 65534));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset policy: denials logged, grants not
    load_directed();
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      write_policy(CFG_LOG_DENIED, pol_denied[p]);
      write_policy(CFG_LOG_ACCEPT, pol_accept[p]);
      n_settings++;
      // sender starves between chunks until the pipe is empty
      for (int c = 0; c < CHUNKS; c++) begin
        load_random(CHUNK_WORDS);
        wait_idle();
      end
    end

    codes_seen = 0;
    for (int i = 0; i < 16; i++) if (code_hits[i] != 0) codes_seen++;
    $display("covered %0d access checks (%0d granted) and %0d rule writes",
             n_checks, n_granted, n_writes);
    $display("over %0d audit policy settings, %0d of 10 decision codes seen, %0d errors",
             n_settings, codes_seen, n_errors);
    if (n_errors == 0) begin
      $display("tb_label_access_check: done, clean");
    end else begin
      $display("tb_label_access_check: done, errors");
    end
    $finish;
  end

endmodule
